/* hdl/lmrs_pkg.sv */
// lmrs_pkg: shared types and constants for the led matrix row scanner
package lmrs_pkg;

   localparam int TYPE_W  = 2;
   localparam int COORD_W = 16;
   localparam int COLOR_W = 3;
   localparam int ROW_IDX_W = 4;
   localparam int MASK_W  = 8;

   localparam int RED_BIT   = 0;
   localparam int GREEN_BIT = 1;
   localparam int BLUE_BIT  = 2;

   typedef enum logic [TYPE_W-1:0] {
      REQ_DRAW  = 2'd0,
      REQ_CLEAR = 2'd1,
      REQ_SWAP  = 2'd2,
      REQ_SCAN  = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_DRAW_RD,
      ST_DRAW_WR,
      ST_CLEAR,
      ST_COPY,
      ST_SCAN_RD,
      ST_SCAN_OUT
   } state_type;

endpackage

/* hdl/led_matrix_row_scanner_unit.sv */
// led_matrix_row_scanner_unit: double-buffered led matrix store with row scan output
//
//   channel  direction  handshake                  payload
//   req      in         req_valid / req_stall      req_type, req_pix_x, req_pix_y, req_pix_color
//   rsp      out        rsp_valid / rsp_stall      rsp_row_index, rsp_red_cols,
//                                                  rsp_green_cols, rsp_blue_cols
//
// all work goes through one row-wide frame memory port pair (one read, one write a cycle).
// draw: accept, row read, row write; swap: sets a pending swap; clear: zeroes the back frame.
// scan tick: row read, output; when it swaps frames it first copies the new front row by row.
// after reset a sweep zeroes both frames row by row; req_stall is high meanwhile.
// a result waits in the output register; a following tick holds in its last step until it drains.
module led_matrix_row_scanner_unit #(
   parameter int COLS = 8,
   parameter int ROWS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [lmrs_pkg::TYPE_W-1:0]          req_type,
   input  logic signed [lmrs_pkg::COORD_W-1:0]  req_pix_x,
   input  logic signed [lmrs_pkg::COORD_W-1:0]  req_pix_y,
   input  logic [lmrs_pkg::COLOR_W-1:0]         req_pix_color,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [lmrs_pkg::ROW_IDX_W-1:0]       rsp_row_index,
   output logic [lmrs_pkg::MASK_W-1:0]          rsp_red_cols,
   output logic [lmrs_pkg::MASK_W-1:0]          rsp_green_cols,
   output logic [lmrs_pkg::MASK_W-1:0]          rsp_blue_cols
);

   localparam int RW     = $clog2(ROWS);
   localparam int CW     = $clog2(ROWS + 1);
   localparam int XW     = (COLS > 1) ? $clog2(COLS) : 1;
   localparam int ADDR_W = RW + 1;
   localparam int WORD_W = COLS * lmrs_pkg::COLOR_W;
   localparam int DEPTH  = 2 ** ADDR_W;

   lmrs_pkg::state_type state_ff, state_in;

   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   logic              back_ff, back_in;
   logic              pending_ff, pending_in;
   logic [RW-1:0]     scan_row_ff, scan_row_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              init_frame_ff, init_frame_in;
   logic [RW-1:0]     draw_row_ff, draw_row_in;
   logic [XW-1:0]     draw_col_ff, draw_col_in;
   logic [lmrs_pkg::COLOR_W-1:0] draw_color_ff, draw_color_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [lmrs_pkg::ROW_IDX_W-1:0] row_index_ff, row_index_in;
   logic [lmrs_pkg::MASK_W-1:0]   red_ff, red_in;
   logic [lmrs_pkg::MASK_W-1:0]   green_ff, green_in;
   logic [lmrs_pkg::MASK_W-1:0]   blue_ff, blue_in;

   logic              accept;
   logic              in_frame;
   logic              last_row;
   logic              copy_done;
   logic              swap_now;
   logic              out_free;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [WORD_W-1:0] wr_data;
   logic [WORD_W-1:0] draw_word;
   logic [CW-1:0]     cnt_prev;

   assign accept    = req_valid && !req_stall;
   assign in_frame  = !req_pix_x[lmrs_pkg::COORD_W-1] && !req_pix_y[lmrs_pkg::COORD_W-1]
                      && (req_pix_x < lmrs_pkg::COORD_W'(COLS))
                      && (req_pix_y < lmrs_pkg::COORD_W'(ROWS));
   assign last_row  = (cnt_ff == CW'(ROWS - 1));
   assign copy_done = (cnt_ff == CW'(ROWS));
   assign swap_now  = (scan_row_ff == '0) && pending_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign cnt_prev  = cnt_ff - CW'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lmrs_pkg::ST_INIT: begin
            if (last_row && init_frame_ff) begin
               state_in = lmrs_pkg::ST_IDLE;
            end
         end
         lmrs_pkg::ST_IDLE: begin
            if (accept) begin
               case (lmrs_pkg::req_kind_type'(req_type))
                  lmrs_pkg::REQ_DRAW: begin
                     if (in_frame) begin
                        state_in = lmrs_pkg::ST_DRAW_RD;
                     end
                  end
                  lmrs_pkg::REQ_CLEAR: state_in = lmrs_pkg::ST_CLEAR;
                  lmrs_pkg::REQ_SWAP:  state_in = lmrs_pkg::ST_IDLE;
                  lmrs_pkg::REQ_SCAN: begin
                     state_in = swap_now ? lmrs_pkg::ST_COPY : lmrs_pkg::ST_SCAN_RD;
                  end
                  default: state_in = lmrs_pkg::ST_IDLE;
               endcase
            end
         end
         lmrs_pkg::ST_DRAW_RD: state_in = lmrs_pkg::ST_DRAW_WR;
         lmrs_pkg::ST_DRAW_WR: state_in = lmrs_pkg::ST_IDLE;
         lmrs_pkg::ST_CLEAR: begin
            if (last_row) begin
               state_in = lmrs_pkg::ST_IDLE;
            end
         end
         lmrs_pkg::ST_COPY: begin
            if (copy_done) begin
               state_in = lmrs_pkg::ST_SCAN_RD;
            end
         end
         lmrs_pkg::ST_SCAN_RD: state_in = lmrs_pkg::ST_SCAN_OUT;
         lmrs_pkg::ST_SCAN_OUT: begin
            if (out_free) begin
               state_in = lmrs_pkg::ST_IDLE;
            end
         end
         default: state_in = lmrs_pkg::ST_INIT;
      endcase
   end

   // memory port controls
   always_comb begin
      req_stall = 1'b1;
      rd_en     = 1'b0;
      rd_addr   = {~back_ff, scan_row_ff};
      wr_en     = 1'b0;
      wr_addr   = {back_ff, cnt_ff[RW-1:0]};
      wr_data   = '0;
      case (state_ff)
         lmrs_pkg::ST_INIT: begin
            wr_en   = 1'b1;
            wr_addr = {init_frame_ff, cnt_ff[RW-1:0]};
         end
         lmrs_pkg::ST_IDLE: req_stall = 1'b0;
         lmrs_pkg::ST_DRAW_RD: begin
            rd_en   = 1'b1;
            rd_addr = {back_ff, draw_row_ff};
         end
         lmrs_pkg::ST_DRAW_WR: begin
            wr_en   = 1'b1;
            wr_addr = {back_ff, draw_row_ff};
            wr_data = draw_word;
         end
         lmrs_pkg::ST_CLEAR: wr_en = 1'b1;
         lmrs_pkg::ST_COPY: begin
            rd_en   = !copy_done;
            rd_addr = {~back_ff, cnt_ff[RW-1:0]};
            wr_en   = (cnt_ff != '0);
            wr_addr = {back_ff, cnt_prev[RW-1:0]};
            wr_data = rd_data_ff;
         end
         lmrs_pkg::ST_SCAN_RD: rd_en = 1'b1;
         lmrs_pkg::ST_SCAN_OUT: req_stall = 1'b1;
         default: req_stall = 1'b1;
      endcase
   end

   // pixel merge into the row word
   always_comb begin
      draw_word = rd_data_ff;
      for (int c = 0; c < COLS; c++) begin
         if (draw_col_ff == XW'(c)) begin
            draw_word[c*lmrs_pkg::COLOR_W +: lmrs_pkg::COLOR_W] = draw_color_ff;
         end
      end
   end

   // control and datapath registers
   always_comb begin
      back_in       = back_ff;
      pending_in    = pending_ff;
      scan_row_in   = scan_row_ff;
      cnt_in        = cnt_ff;
      init_frame_in = init_frame_ff;
      draw_row_in   = draw_row_ff;
      draw_col_in   = draw_col_ff;
      draw_color_in = draw_color_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      row_index_in  = row_index_ff;
      red_in        = red_ff;
      green_in      = green_ff;
      blue_in       = blue_ff;
      case (state_ff)
         lmrs_pkg::ST_INIT: begin
            if (last_row) begin
               cnt_in        = '0;
               init_frame_in = 1'b1;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         lmrs_pkg::ST_IDLE: begin
            cnt_in        = '0;
            draw_row_in   = req_pix_y[RW-1:0];
            draw_col_in   = req_pix_x[XW-1:0];
            draw_color_in = req_pix_color;
            if (accept) begin
               case (lmrs_pkg::req_kind_type'(req_type))
                  lmrs_pkg::REQ_CLEAR: pending_in = 1'b1;
                  lmrs_pkg::REQ_SWAP:  pending_in = 1'b1;
                  lmrs_pkg::REQ_SCAN: begin
                     if (swap_now) begin
                        back_in    = ~back_ff;
                        pending_in = 1'b0;
                     end
                  end
                  default: pending_in = pending_ff;
               endcase
            end
         end
         lmrs_pkg::ST_CLEAR: cnt_in = cnt_ff + CW'(1);
         lmrs_pkg::ST_COPY:  cnt_in = cnt_ff + CW'(1);
         lmrs_pkg::ST_SCAN_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               row_index_in = lmrs_pkg::ROW_IDX_W'(scan_row_ff);
               red_in       = '0;
               green_in     = '0;
               blue_in      = '0;
               for (int c = 0; c < lmrs_pkg::MASK_W; c++) begin
                  if (c < COLS) begin
                     red_in[c]   = rd_data_ff[c*lmrs_pkg::COLOR_W + lmrs_pkg::RED_BIT];
                     green_in[c] = rd_data_ff[c*lmrs_pkg::COLOR_W + lmrs_pkg::GREEN_BIT];
                     blue_in[c]  = rd_data_ff[c*lmrs_pkg::COLOR_W + lmrs_pkg::BLUE_BIT];
                  end
               end
               scan_row_in = (scan_row_ff == RW'(ROWS - 1)) ? '0 : scan_row_ff + RW'(1);
            end
         end
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= lmrs_pkg::ST_INIT;
         back_ff       <= 1'b0;
         pending_ff    <= 1'b0;
         scan_row_ff   <= '0;
         cnt_ff        <= '0;
         init_frame_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         back_ff       <= back_in;
         pending_ff    <= pending_in;
         scan_row_ff   <= scan_row_in;
         cnt_ff        <= cnt_in;
         init_frame_ff <= init_frame_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      draw_row_ff   <= draw_row_in;
      draw_col_ff   <= draw_col_in;
      draw_color_ff <= draw_color_in;
      row_index_ff  <= row_index_in;
      red_ff        <= red_in;
      green_ff      <= green_in;
      blue_ff       <= blue_in;
   end

   // frame memory, one row per word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_row_index  = row_index_ff;
   assign rsp_red_cols   = red_ff;
   assign rsp_green_cols = green_ff;
   assign rsp_blue_cols  = blue_ff;

   a_swap_flips: assert property (@(posedge clock) disable iff (reset)
      (accept && req_type == lmrs_pkg::REQ_SCAN && swap_now)
      |=> (back_ff != $past(back_ff)) && !pending_ff)
      else $error("frame swap not taken on scan tick");

   a_row_range: assert property (@(posedge clock) disable iff (reset)
      scan_row_ff <= RW'(ROWS - 1))
      else $error("scan row out of range");

   a_copy_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == lmrs_pkg::ST_COPY |-> cnt_ff <= CW'(ROWS))
      else $error("copy counter overrun");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == lmrs_pkg::ST_SCAN_OUT)
      else $error("result raised outside scan output step");

endmodule
